// ----- rtl/sfti_pkg.sv -----
// Shared constants and codes for the sorted frame timestamp index.
package sfti_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int RATE_WINDOW_DEF = 20;

    localparam int STAMP_W  = 48;
    localparam int INDEX_W  = 32;
    localparam int RESULT_W = 64;
    localparam int PERIOD_W = 20;
    localparam int ACTION_W = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(33333);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(1000000);
    localparam int                  RATE_TOL     = 4000;
    localparam int                  KEY_BACKOFF  = 1000000;

    localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_NEAREST  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_KEYFRAME = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TIME2IDX = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_IDX2TIME = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_VRATE  = 1'b1;

endpackage

// ----- rtl/sfti_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sfti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sfti_div.sv -----
// Restoring divider, one quotient bit per cycle.
module sfti_div
    import sfti_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CNT_W = $clog2(NW + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } div_state_t;

    div_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;

    assign trial = {rem_reg, quo_reg[NW-1]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    quo_next   = dividend;
                    rem_next   = '0;
                    dvs_next   = divisor;
                    cnt_next   = CNT_W'(NW);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = DW'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DW-1:0];
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            dvs_reg   <= dvs_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/sorted_frame_timestamp_index_core.sv -----
// Sorted frame timestamp index: top level with action sequencer.
// One beat is handled at a time by a sequencer walking the timestamp RAM, one entry read
// at a time. Register scans pos entries to find the slot, shifts the count-pos tail entries
// up, and reads up to min(count, RATE_WINDOW) entries for the rate check; nearest, time to
// index and keyframe before scan about pos entries; index to time reads one entry.
// Nearest on an empty table, and time to index on an empty table or past the last entry,
// fall back on the restoring divider. The longest beats are a register into the front of
// a 63-entry table and a time to index past the end of a full table. A finished result
// waits in the output register while the next beat is taken.
module sorted_frame_timestamp_index_core
    import sfti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int RATE_WINDOW = RATE_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [PERIOD_W-1:0]                cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ACTION_W-1:0]                action,
    input  logic signed [STAMP_W-1:0]          time_us,
    input  logic                               is_keyframe,
    input  logic signed [INDEX_W-1:0]          frame_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [RESULT_W-1:0]         result_value,
    output logic                               status,
    output logic                               variable_rate,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]   entry_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = STAMP_W + 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POST,
        S_NEAR_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RATE_RD,
        S_RATE_CHK,
        S_RATE_CMP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ROUND_A,
        S_ROUND_B,
        S_IDX_WAIT,
        S_FINISH
    } seq_state_t;

    seq_state_t                  state_reg, state_next;
    logic [ACTION_W-1:0]         act_reg, act_next;
    logic signed [STAMP_W-1:0]   t_reg, t_next;
    logic                        key_reg, key_next;
    logic signed [INDEX_W-1:0]   fidx_reg, fidx_next;
    logic [CW-1:0]               held_reg, held_next;
    logic                        flag_reg, flag_next;
    logic [PERIOD_W-1:0]         period_reg, period_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               jdx_reg, jdx_next;
    logic signed [STAMP_W-1:0]   prev_reg, prev_next;
    logic signed [STAMP_W-1:0]   cur_reg, cur_next;
    logic signed [STAMP_W:0]     d0_reg, d0_next;
    logic signed [STAMP_W:0]     delta_reg, delta_next;
    logic signed [STAMP_W:0]     da_reg, da_next;
    logic signed [STAMP_W:0]     db_reg, db_next;
    logic [STAMP_W:0]            mag_reg, mag_next;
    logic signed [RESULT_W-1:0]  res_reg, res_next;
    logic                        stat_reg, stat_next;
    logic                        ovalid_reg, ovalid_next;
    logic signed [RESULT_W-1:0]  oval_reg, oval_next;
    logic                        ostat_reg, ostat_next;
    logic                        orate_reg, orate_next;
    logic [CW-1:0]               ocount_reg, ocount_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [EW-1:0]               ram_rdata;

    logic                        div_start;
    logic                        div_done;
    logic [STAMP_W-1:0]          div_quot;
    logic [PERIOD_W-1:0]         div_rem;

    logic [PERIOD_W-1:0]         per_eff;
    logic [STAMP_W-1:0]          t_abs;
    logic signed [STAMP_W-1:0]   rd_stamp;
    logic                        rd_key;
    logic [CW-1:0]               idx_inc;
    logic [CW-1:0]               jdx_inc;
    logic [CW-1:0]               rate_lim;
    logic                        round_up;
    logic signed [STAMP_W:0]     back_off;
    logic signed [STAMP_W+1:0]   dev;
    logic signed [INDEX_W+PERIOD_W:0] i2t_prod;

    assign per_eff  = (period_reg == '0) ? PERIOD_W'(1) :
                      (period_reg > PERIOD_MAX) ? PERIOD_MAX : period_reg;
    assign t_abs    = t_reg[STAMP_W-1] ? STAMP_W'(-t_reg) : t_reg;
    assign rd_stamp = ram_rdata[EW-1:1];
    assign rd_key   = ram_rdata[0];
    assign idx_inc  = CW'(idx_reg + 1'b1);
    assign jdx_inc  = CW'(jdx_reg + 1'b1);
    assign rate_lim = (32'(held_reg) < RATE_WINDOW) ? held_reg : CW'(RATE_WINDOW);
    assign round_up = {div_rem, 1'b0} >= {1'b0, per_eff};
    assign back_off = (STAMP_W+1)'(t_reg) - (STAMP_W+1)'(KEY_BACKOFF);
    assign dev      = (STAMP_W+2)'(delta_reg) - (STAMP_W+2)'(d0_reg);
    assign i2t_prod = fidx_reg * $signed({1'b0, per_eff});

    sfti_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfti_div #(
        .NW (STAMP_W),
        .DW (PERIOD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (t_abs),
        .divisor  (per_eff),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        t_next      = t_reg;
        key_next    = key_reg;
        fidx_next   = fidx_reg;
        held_next   = held_reg;
        flag_next   = flag_reg;
        period_next = period_reg;
        idx_next    = idx_reg;
        jdx_next    = jdx_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        d0_next     = d0_reg;
        delta_next  = delta_reg;
        da_next     = da_reg;
        db_next     = db_reg;
        mag_next    = mag_reg;
        res_next    = res_reg;
        stat_next   = stat_reg;
        oval_next   = oval_reg;
        ostat_next  = ostat_reg;
        orate_next  = orate_reg;
        ocount_next = ocount_reg;
        ovalid_next = ovalid_reg & ~out_ready;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = {t_reg, key_reg};
        ram_raddr   = idx_reg[AW-1:0];
        div_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    t_next     = time_us;
                    key_next   = is_keyframe;
                    fidx_next  = frame_index;
                    res_next   = '0;
                    stat_next  = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                idx_next = '0;
                case (act_reg)
                    ACT_REGISTER, ACT_NEAREST, ACT_TIME2IDX:
                    begin
                        state_next = (held_reg == '0) ? S_POST : S_SCAN_RD;
                    end
                    ACT_KEYFRAME:
                    begin
                        if (held_reg == '0)
                        begin
                            res_next   = back_off[STAMP_W] ? '0 : RESULT_W'(back_off);
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    ACT_IDX2TIME:
                    begin
                        if (!fidx_reg[INDEX_W-1] && fidx_reg < $signed(32'(held_reg)))
                        begin
                            ram_raddr  = fidx_reg[AW-1:0];
                            state_next = S_IDX_WAIT;
                        end
                        else
                        begin
                            res_next   = RESULT_W'(i2t_prod);
                            state_next = S_FINISH;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        held_next  = '0;
                        flag_next  = 1'b0;
                        state_next = S_FINISH;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_SCAN_RD:
            begin
                ram_raddr  = idx_reg[AW-1:0];
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (act_reg == ACT_KEYFRAME)
                begin
                    if (idx_reg == '0)
                    begin
                        res_next = RESULT_W'(rd_stamp);
                    end
                    if (rd_stamp <= t_reg)
                    begin
                        if (rd_key)
                        begin
                            res_next = RESULT_W'(rd_stamp);
                        end
                        idx_next   = idx_inc;
                        state_next = (idx_inc == held_reg) ? S_FINISH : S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (rd_stamp < t_reg)
                begin
                    prev_next  = rd_stamp;
                    idx_next   = idx_inc;
                    state_next = (idx_inc == held_reg) ? S_POST : S_SCAN_RD;
                end
                else
                begin
                    cur_next   = rd_stamp;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                case (act_reg)
                    ACT_REGISTER:
                    begin
                        if (idx_reg < held_reg && cur_reg == t_reg)
                        begin
                            ram_we     = 1'b1;
                            state_next = S_FINISH;
                        end
                        else if (held_reg == CW'(TABLE_DEPTH))
                        begin
                            stat_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            jdx_next   = held_reg;
                            state_next = (held_reg > idx_reg) ? S_SHIFT_RD : S_PUT;
                        end
                    end
                    ACT_NEAREST:
                    begin
                        if (held_reg == '0)
                        begin
                            state_next = S_DIV_GO;
                        end
                        else if (idx_reg >= held_reg)
                        begin
                            res_next   = RESULT_W'(prev_reg);
                            state_next = S_FINISH;
                        end
                        else if (idx_reg == '0)
                        begin
                            res_next   = RESULT_W'(cur_reg);
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            da_next    = (STAMP_W+1)'(t_reg) - (STAMP_W+1)'(prev_reg);
                            db_next    = (STAMP_W+1)'(cur_reg) - (STAMP_W+1)'(t_reg);
                            state_next = S_NEAR_CMP;
                        end
                    end
                    default:
                    begin
                        if (idx_reg < held_reg)
                        begin
                            res_next   = RESULT_W'(idx_reg);
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_DIV_GO;
                        end
                    end
                endcase
            end
            S_NEAR_CMP:
            begin
                res_next   = (da_reg <= db_reg) ? RESULT_W'(prev_reg) : RESULT_W'(cur_reg);
                state_next = S_FINISH;
            end
            S_SHIFT_RD:
            begin
                ram_raddr  = AW'(jdx_reg - 1'b1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = jdx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                jdx_next   = CW'(jdx_reg - 1'b1);
                state_next = (CW'(jdx_reg - 1'b1) > idx_reg) ? S_SHIFT_RD : S_PUT;
            end
            S_PUT:
            begin
                ram_we    = 1'b1;
                held_next = CW'(held_reg + 1'b1);
                jdx_next  = '0;
                state_next = (32'(held_reg) + 1 >= 4) ? S_RATE_RD : S_FINISH;
            end
            S_RATE_RD:
            begin
                ram_raddr  = jdx_reg[AW-1:0];
                state_next = S_RATE_CHK;
            end
            S_RATE_CHK:
            begin
                prev_next = rd_stamp;
                jdx_next  = jdx_inc;
                if (jdx_reg == '0)
                begin
                    state_next = S_RATE_RD;
                end
                else if (jdx_reg == CW'(1))
                begin
                    d0_next    = (STAMP_W+1)'(rd_stamp) - (STAMP_W+1)'(prev_reg);
                    state_next = (jdx_inc < rate_lim) ? S_RATE_RD : S_FINISH;
                end
                else
                begin
                    delta_next = (STAMP_W+1)'(rd_stamp) - (STAMP_W+1)'(prev_reg);
                    state_next = S_RATE_CMP;
                end
            end
            S_RATE_CMP:
            begin
                if (dev > (STAMP_W+2)'(RATE_TOL) || dev < -(STAMP_W+2)'(RATE_TOL))
                begin
                    flag_next  = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = (jdx_reg < rate_lim) ? S_RATE_RD : S_FINISH;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_ROUND_A;
                end
            end
            S_ROUND_A:
            begin
                if (act_reg == ACT_NEAREST)
                begin
                    // nearest multiple: |t| - r, plus one period when rounding up
                    mag_next = (STAMP_W+1)'(t_abs) - (STAMP_W+1)'(div_rem)
                             + (round_up ? (STAMP_W+1)'(per_eff) : '0);
                end
                else
                begin
                    mag_next = (STAMP_W+1)'(div_quot) + (STAMP_W+1)'(round_up);
                end
                state_next = S_ROUND_B;
            end
            S_ROUND_B:
            begin
                res_next   = t_reg[STAMP_W-1] ? -RESULT_W'(mag_reg) : RESULT_W'(mag_reg);
                state_next = S_FINISH;
            end
            S_IDX_WAIT:
            begin
                res_next   = RESULT_W'(rd_stamp);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    oval_next   = res_reg;
                    ostat_next  = stat_reg;
                    orate_next  = flag_reg;
                    ocount_next = held_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD: period_next = cfg_data;
                CFG_VRATE:  flag_next   = cfg_data[0];
                default:    period_next = period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= '0;
            t_reg      <= '0;
            key_reg    <= 1'b0;
            fidx_reg   <= '0;
            held_reg   <= '0;
            flag_reg   <= 1'b0;
            period_reg <= PERIOD_RESET;
            idx_reg    <= '0;
            jdx_reg    <= '0;
            prev_reg   <= '0;
            cur_reg    <= '0;
            d0_reg     <= '0;
            delta_reg  <= '0;
            da_reg     <= '0;
            db_reg     <= '0;
            mag_reg    <= '0;
            res_reg    <= '0;
            stat_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            oval_reg   <= '0;
            ostat_reg  <= 1'b0;
            orate_reg  <= 1'b0;
            ocount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            t_reg      <= t_next;
            key_reg    <= key_next;
            fidx_reg   <= fidx_next;
            held_reg   <= held_next;
            flag_reg   <= flag_next;
            period_reg <= period_next;
            idx_reg    <= idx_next;
            jdx_reg    <= jdx_next;
            prev_reg   <= prev_next;
            cur_reg    <= cur_next;
            d0_reg     <= d0_next;
            delta_reg  <= delta_next;
            da_reg     <= da_next;
            db_reg     <= db_next;
            mag_reg    <= mag_next;
            res_reg    <= res_next;
            stat_reg   <= stat_next;
            ovalid_reg <= ovalid_next;
            oval_reg   <= oval_next;
            ostat_reg  <= ostat_next;
            orate_reg  <= orate_next;
            ocount_reg <= ocount_next;
        end
    end

    assign out_valid     = ovalid_reg;
    assign result_value  = oval_reg;
    assign status        = ostat_reg;
    assign variable_rate = orate_reg;
    assign entry_count   = ocount_reg;

endmodule

// ----- rtl/sfti_checker.sv -----
// Port-level checks for the sorted frame timestamp index, bound to the top level.
module sfti_checker
    import sfti_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [RESULT_W-1:0]       result_value,
    input logic                             status,
    input logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

    // a dropped register answers zero with a full table
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> result_value == '0 && 32'(entry_count) == TABLE_DEPTH)
        else $error("dropped register without full table");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(entry_count) <= TABLE_DEPTH)
        else $error("entry count beyond depth");

    // one beat in flight: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held after accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result changed while stalled");

endmodule

bind sorted_frame_timestamp_index_core sfti_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sfti_checker (.*);
